// ===== sv/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned LEN_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_PHASE = 2'd0,
		CFG_LONG_PHASE  = 2'd1,
		CFG_ACK_POLL    = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	localparam logic [LEN_W-1:0] SHORT_RST = 16'd2;
	localparam logic [LEN_W-1:0] LONG_RST  = 16'd5;
	localparam logic [LEN_W-1:0] POLL_RST  = 16'd1000;

	// effective lengths, zero already mapped to one
	typedef struct packed {
		logic [LEN_W-1:0] short_len;
		logic [LEN_W-1:0] long_len;
		logic [LEN_W-1:0] poll_len;
	} cfg_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/i2cm_if.sv =====
`default_nettype none
interface i2cm_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] mode;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd_valid, mode, tx_byte, send_ack, sda_in, input ready);
	modport sink (input valid, cmd_valid, mode, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_byte, ack_seen,
		input ready);
	modport sink (input valid, scl_drive, sda_drive, busy_res, done_res, rx_byte, ack_seen,
		output ready);
endinterface

interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/i2cm_cfg_regs.sv =====
`default_nettype none
module i2cm_cfg_regs
	import i2cm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	i2cm_cfg_if.sink  cfg,
	output cfg_t      cfg_eff
);

	logic [LEN_W-1:0] short_q;
	logic [LEN_W-1:0] long_q;
	logic [LEN_W-1:0] poll_q;
	logic             wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= SHORT_RST;
			long_q  <= LONG_RST;
			poll_q  <= POLL_RST;
		end else if (wr) begin
			case (cfg_idx_t'(cfg.index))
				CFG_SHORT_PHASE: short_q <= cfg.data;
				CFG_LONG_PHASE:  long_q  <= cfg.data;
				CFG_ACK_POLL:    poll_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_eff.short_len = (short_q == '0) ? LEN_W'(1) : short_q;
	assign cfg_eff.long_len  = (long_q  == '0) ? LEN_W'(1) : long_q;
	assign cfg_eff.poll_len  = (poll_q  == '0) ? LEN_W'(1) : poll_q;

endmodule
`default_nettype wire

// ===== sv/i2cm_seq.sv =====
`default_nettype none
module i2cm_seq
	import i2cm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire tick_t tick,
	input  wire cfg_t  cfg_eff,
	output res_t       res
);

	typedef enum logic [4:0] {
		P_IDLE   = 5'd0,
		P_ST_A   = 5'd1,
		P_ST_B   = 5'd2,
		P_ST_C   = 5'd3,
		P_SP_A   = 5'd4,
		P_SP_B   = 5'd5,
		P_SP_C   = 5'd6,
		P_W_LOW  = 5'd7,
		P_W_DATA = 5'd8,
		P_W_HIGH = 5'd9,
		P_W_RLOW = 5'd10,
		P_W_REL  = 5'd11,
		P_A_REL  = 5'd12,
		P_A_HIGH = 5'd13,
		P_A_POLL = 5'd14,
		P_A_END  = 5'd15,
		P_R_LOW  = 5'd16,
		P_R_HIGH = 5'd17,
		P_R_HOLD = 5'd18,
		P_R_END  = 5'd19,
		P_K_LOW  = 5'd20,
		P_K_SDA  = 5'd21,
		P_K_HIGH = 5'd22,
		P_K_LOW2 = 5'd23,
		P_K_REL  = 5'd24
	} phase_t;

	phase_t           phase_q, n_phase;
	logic [LEN_W-1:0] timer_q, n_timer;
	logic [3:0]       bit_idx_q, n_bit_idx;
	logic [7:0]       shift_q, n_shift;
	logic [LEN_W-1:0] poll_q, n_poll;
	logic             ack_choice_q, n_ack_choice;
	logic             scl_q, n_scl;
	logic             sda_q, n_sda;
	logic             last_ack_q, n_last_ack;
	logic [7:0]       rx_hold_q, n_rx_hold;
	logic             done;

	// pending phase load
	logic             sp_en;
	phase_t           sp_phase;
	logic             sp_scl;
	logic             sp_sda_set;
	logic             sp_sda;
	logic             sp_long;

	always_comb begin
		logic [LEN_W-1:0] t_dec;
		logic [LEN_W-1:0] p_dec;
		logic [7:0]       sh;
		logic [3:0]       bi;

		n_phase      = phase_q;
		n_timer      = timer_q;
		n_bit_idx    = bit_idx_q;
		n_shift      = shift_q;
		n_poll       = poll_q;
		n_ack_choice = ack_choice_q;
		n_scl        = scl_q;
		n_sda        = sda_q;
		n_last_ack   = last_ack_q;
		n_rx_hold    = rx_hold_q;
		done         = 1'b0;
		sp_en        = 1'b0;
		sp_phase     = P_IDLE;
		sp_scl       = 1'b1;
		sp_sda_set   = 1'b0;
		sp_sda       = 1'b1;
		sp_long      = 1'b0;
		t_dec        = (timer_q != '0) ? timer_q - LEN_W'(1) : '0;
		p_dec        = poll_q - LEN_W'(1);
		sh           = (phase_q == P_R_HIGH) ? {shift_q[6:0], tick.sda_in} : shift_q;
		bi           = bit_idx_q + 4'd1;

		if (phase_q == P_IDLE) begin
			if (tick.cmd_valid) begin
				n_bit_idx = '0;
				sp_en     = 1'b1;
				case (mode_t'(tick.mode))
					MODE_START: begin
						sp_phase = P_ST_A; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b1;
						sp_long = 1'b1;
					end
					MODE_STOP: begin
						sp_phase = P_SP_A; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = 1'b0;
						sp_long = 1'b1;
					end
					MODE_WRITE: begin
						n_shift  = tick.tx_byte;
						sp_phase = P_W_LOW; sp_scl = 1'b0;
					end
					default: begin
						n_shift      = '0;
						n_ack_choice = tick.send_ack;
						sp_phase = P_R_LOW; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = 1'b1;
					end
				endcase
			end
		end else if (phase_q == P_A_POLL) begin
			if (!tick.sda_in) begin
				sp_en = 1'b1; sp_phase = P_A_END; sp_scl = 1'b0;
			end else begin
				n_poll = p_dec;
				if (p_dec == '0) begin
					n_scl      = 1'b0;
					n_last_ack = 1'b0;
					n_phase    = P_IDLE;
					n_timer    = '0;
					done       = 1'b1;
				end
			end
		end else begin
			n_timer = t_dec;
			if (t_dec == '0) begin
				n_shift = sh;
				sp_en   = 1'b1;
				case (phase_q)
					P_ST_A: begin
						sp_phase = P_ST_B; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b0;
						sp_long = 1'b1;
					end
					P_ST_B: begin
						sp_phase = P_ST_C; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = 1'b0;
						sp_long = 1'b1;
					end
					P_SP_A: begin
						sp_phase = P_SP_B; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b0;
						sp_long = 1'b1;
					end
					P_SP_B: begin
						sp_phase = P_SP_C; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b1;
						sp_long = 1'b1;
					end
					P_W_LOW: begin
						sp_phase = P_W_DATA; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = sh[7];
					end
					P_W_DATA: begin
						sp_phase = P_W_HIGH; sp_scl = 1'b1; sp_long = 1'b1;
					end
					P_W_HIGH: begin
						n_shift   = {sh[6:0], 1'b0};
						n_bit_idx = bi;
						sp_phase  = (bi >= 4'd8) ? P_W_RLOW : P_W_LOW;
						sp_scl    = 1'b0;
					end
					P_W_RLOW: begin
						sp_phase = P_W_REL; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = 1'b1;
					end
					P_W_REL: begin
						sp_phase = P_A_REL; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = 1'b1;
					end
					P_A_REL: begin
						sp_phase = P_A_HIGH; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b1;
					end
					P_A_HIGH: begin
						sp_en   = 1'b0;
						n_phase = P_A_POLL;
						n_timer = '0;
						n_poll  = cfg_eff.poll_len;
					end
					P_R_LOW: begin
						sp_phase = P_R_HIGH; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b1;
					end
					P_R_HIGH: begin
						sp_phase = P_R_HOLD; sp_scl = 1'b1; sp_sda_set = 1'b1; sp_sda = 1'b1;
					end
					P_R_HOLD: begin
						n_bit_idx  = bi;
						sp_phase   = (bi >= 4'd8) ? P_R_END : P_R_LOW;
						sp_scl     = 1'b0;
						sp_sda_set = 1'b1;
						sp_sda     = 1'b1;
					end
					P_R_END: begin
						sp_phase = P_K_LOW; sp_scl = 1'b0;
					end
					P_K_LOW: begin
						sp_phase = P_K_SDA; sp_scl = 1'b0; sp_sda_set = 1'b1;
						sp_sda = !ack_choice_q;
					end
					P_K_SDA: begin
						sp_phase = P_K_HIGH; sp_scl = 1'b1; sp_long = 1'b1;
					end
					P_K_HIGH: begin
						sp_phase = P_K_LOW2; sp_scl = 1'b0;
					end
					P_K_LOW2: begin
						if (ack_choice_q) begin
							sp_phase = P_K_REL; sp_scl = 1'b0; sp_sda_set = 1'b1; sp_sda = 1'b1;
						end else begin
							sp_en     = 1'b0;
							n_rx_hold = sh;
							n_phase   = P_IDLE;
							n_timer   = '0;
							done      = 1'b1;
						end
					end
					P_K_REL: begin
						sp_en     = 1'b0;
						n_rx_hold = sh;
						n_phase   = P_IDLE;
						n_timer   = '0;
						done      = 1'b1;
					end
					P_A_END: begin
						sp_en      = 1'b0;
						n_last_ack = 1'b1;
						n_phase    = P_IDLE;
						n_timer    = '0;
						done       = 1'b1;
					end
					default: begin
						sp_en   = 1'b0;
						n_phase = P_IDLE;
						n_timer = '0;
						done    = 1'b1;
					end
				endcase
			end
		end

		if (sp_en) begin
			n_phase = sp_phase;
			n_scl   = sp_scl;
			n_timer = sp_long ? cfg_eff.long_len : cfg_eff.short_len;
			if (sp_sda_set) begin
				n_sda = sp_sda;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= P_IDLE;
			timer_q      <= '0;
			bit_idx_q    <= '0;
			shift_q      <= '0;
			poll_q       <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			last_ack_q   <= 1'b0;
			rx_hold_q    <= '0;
		end else if (take) begin
			phase_q      <= n_phase;
			timer_q      <= n_timer;
			bit_idx_q    <= n_bit_idx;
			shift_q      <= n_shift;
			poll_q       <= n_poll;
			ack_choice_q <= n_ack_choice;
			scl_q        <= n_scl;
			sda_q        <= n_sda;
			last_ack_q   <= n_last_ack;
			rx_hold_q    <= n_rx_hold;
		end
	end

	assign res.scl_drive = n_scl;
	assign res.sda_drive = n_sda;
	assign res.busy_res  = (n_phase != P_IDLE);
	assign res.done_res  = done;
	assign res.rx_byte   = n_rx_hold;
	assign res.ack_seen  = n_last_ack;

	a_timed_phase_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != P_IDLE && phase_q != P_A_POLL) |-> (timer_q != '0))
		else $error("timed phase with expired timer");

	a_poll_state: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_A_POLL) |-> (timer_q == '0 && poll_q != '0))
		else $error("ack poll with bad counters");

	a_bit_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q <= 4'd8)
		else $error("bit index out of range");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> ($stable(phase_q) && $stable(timer_q) && $stable(shift_q)))
		else $error("state moved without a tick");

endmodule
`default_nettype wire

// ===== sv/i2cm_out_reg.sv =====
`default_nettype none
module i2cm_out_reg
	import i2cm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire res_t  res,
	output logic       free,
	i2cm_res_if.source res_out
);

	logic valid_q;
	res_t data_q;

	assign free = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign res_out.valid     = valid_q;
	assign res_out.scl_drive = data_q.scl_drive;
	assign res_out.sda_drive = data_q.sda_drive;
	assign res_out.busy_res  = data_q.busy_res;
	assign res_out.done_res  = data_q.done_res;
	assign res_out.rx_byte   = data_q.rx_byte;
	assign res_out.ack_seen  = data_q.ack_seen;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded word not presented");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("word loaded over a stalled one");

endmodule
`default_nettype wire

// ===== sv/i2c_master_byte_engine_unit.sv =====
`default_nettype none
// I2C master byte engine, one bus timing tick per input word.
// tick_in: each word is one tick: an optional command (cmd_valid, mode,
//   tx_byte, send_ack) and the sampled SDA level. Commands are only taken
//   while the engine is idle; otherwise cmd_valid is ignored.
// res_out: one word per tick with SCL/SDA drive levels, busy, a done pulse,
//   the last received byte and the last write's acknowledge result.
// cfg: register writes (0 short phase, 1 long phase, 2 ack poll limit),
//   always ready; write only while the engine is idle.
// Latency: the result word for a tick is presented the cycle after the tick
//   is accepted, from a single output register.
// Throughput: one tick per cycle while res_out is not stalled; the next-state
//   logic is one pass from the state registers to the output register.
// Stall: while a result waits and res_out.ready is low, tick_in.ready is low;
//   when the waiting word is taken in the same cycle a new tick is accepted.
// Reset: bus released (SCL and SDA high), idle, registers at 2, 5 and 1000,
//   received byte and ack result cleared, output register empty.
module i2c_master_byte_engine_unit
	import i2cm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	i2cm_tick_if.sink  tick_in,
	i2cm_res_if.source res_out,
	i2cm_cfg_if.sink   cfg
);

	cfg_t  cfg_eff;
	tick_t tick;
	res_t  res;
	logic  free;
	logic  take;

	assign tick.cmd_valid = tick_in.cmd_valid;
	assign tick.mode      = tick_in.mode;
	assign tick.tx_byte   = tick_in.tx_byte;
	assign tick.send_ack  = tick_in.send_ack;
	assign tick.sda_in    = tick_in.sda_in;

	assign tick_in.ready = free;
	assign take          = tick_in.valid && free;

	i2cm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_eff (cfg_eff)
	);

	i2cm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.tick    (tick),
		.cfg_eff (cfg_eff),
		.res     (res)
	);

	i2cm_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (take),
		.res     (res),
		.free    (free),
		.res_out (res_out)
	);

endmodule
`default_nettype wire
